FILE: design/automation_waveform_generator_defines.svh
// Assertion macros for the automation waveform generator checker.
// No dependencies; included by the checker file.
`ifndef AUTOMATION_WAVEFORM_GENERATOR_DEFINES_SVH
`define AUTOMATION_WAVEFORM_GENERATOR_DEFINES_SVH

// Clocked assertion, switched off while reset is held.
`define AWG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked implication, antecedent a and consequent b.
`define AWG_ASSERT_IMP(lbl, a, b, msg) \
  `AWG_ASSERT(lbl, (a) |-> (b), msg)

`endif

FILE: design/awg_pkg.sv
// Shared constants, types and the quarter-wave sine table of the waveform generator.
// No dependencies.
package awg_pkg;

  localparam int unsigned QUARTER_SINE_ENTRIES = 256;
  localparam int unsigned IDX_W      = $clog2(QUARTER_SINE_ENTRIES);
  localparam int unsigned ANGLE_W    = IDX_W + 2;
  localparam int unsigned QUO_W      = (ANGLE_W > 9) ? ANGLE_W : 9;
  localparam int unsigned DIVD_W     = 16 + QUO_W;
  localparam int unsigned STEPS      = 4;
  localparam int unsigned MOD_STAGES = 16 / STEPS;
  localparam int unsigned QUO_STAGES = (QUO_W + STEPS - 1) / STEPS;
  // input reg + modulo + prep (2) + quotient input reg + quotient + post (3)
  localparam int unsigned LATENCY    = 1 + MOD_STAGES + 2 + 1 + QUO_STAGES + 3;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  typedef enum logic [2:0] {
    WAVE_FLAT   = 3'd0,
    WAVE_SINE   = 3'd1,
    WAVE_SQUARE = 3'd2,
    WAVE_SAW    = 3'd3,
    WAVE_TRI    = 3'd4
  } wave_e;

  typedef enum logic [2:0] {
    CFG_WAVEFORM  = 3'd0,
    CFG_AMPLITUDE = 3'd1,
    CFG_PERIOD    = 3'd2,
    CFG_PHASE     = 3'd3,
    CFG_CENTER    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  wave;
    logic [6:0]  amp;
    logic [15:0] period;   // already forced to at least 2
    logic [14:0] half;     // period / 2
    logic [15:0] phase;
    logic [6:0]  center;
  } cfg_t;

  typedef struct packed {
    logic [15:0] position;
    logic        last;
  } beat_t;

  typedef logic [14:0] sine_tab_t [0:QUARTER_SINE_ENTRIES];

  // Q0.15 quarter sine by Q30 Taylor series, truncating each term.
  function automatic sine_tab_t build_sine_table();
    sine_tab_t   tab;
    logic [63:0] x, x2, term, pos, neg, s;
    for (int i = 0; i <= QUARTER_SINE_ENTRIES; i++) begin
      if (i == QUARTER_SINE_ENTRIES) begin
        tab[i] = 15'd32767;
      end else begin
        x    = (HALF_PI_Q30 * 64'(i)) / QUARTER_SINE_ENTRIES;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = '0;
        for (int k = 1; k <= 7; k++) begin
          term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) neg = neg + term;
          else            pos = pos + term;
        end
        s = (neg > pos) ? 64'd0 : pos - neg;
        if (s > ONE_Q30) s = ONE_Q30;
        tab[i] = 15'((s * 64'd32767 + (ONE_Q30 >> 1)) >> 30);
      end
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

FILE: design/awg_mod.sv
// Pipelined (position + phase) mod period, restoring, STEPS bits a stage.
// Depends on awg_pkg.
module awg_mod (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  awg_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  input  awg_pkg::beat_t beat_i,
  output logic           valid_o,
  output awg_pkg::beat_t beat_o,
  output logic [15:0]    m_o
);

  logic           vld_q [0:awg_pkg::MOD_STAGES];
  awg_pkg::beat_t pay_q [0:awg_pkg::MOD_STAGES];
  logic [16:0]    rem_q [0:awg_pkg::MOD_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else         vld_q[0] <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    pay_q[0] <= beat_i;
    rem_q[0] <= 17'(beat_i.position) + 17'(cfg_i.phase);
  end

  for (genvar g = 0; g < awg_pkg::MOD_STAGES; g++) begin : g_stage
    logic [16:0] rem_d;
    always_comb begin
      rem_d = rem_q[g];
      for (int k = 0; k < awg_pkg::STEPS; k++) begin
        if ({16'b0, rem_d} >= ({17'b0, cfg_i.period} << (15 - g * awg_pkg::STEPS - k))) begin
          rem_d = rem_d - 17'({17'b0, cfg_i.period} << (15 - g * awg_pkg::STEPS - k));
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[g+1] <= 1'b0;
      else         vld_q[g+1] <= vld_q[g];
    end
    always_ff @(posedge clk_i) begin
      rem_q[g+1] <= rem_d;
      pay_q[g+1] <= pay_q[g];
    end
  end

  assign valid_o = vld_q[awg_pkg::MOD_STAGES];
  assign beat_o  = pay_q[awg_pkg::MOD_STAGES];
  assign m_o     = rem_q[awg_pkg::MOD_STAGES][15:0];

endmodule

FILE: design/awg_prep.sv
// Forms 2*A*m, the half-period flag and the dividend for the shared divider.
// Depends on awg_pkg.
module awg_prep (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  awg_pkg::cfg_t              cfg_i,
  input  logic                       valid_i,
  input  awg_pkg::beat_t             beat_i,
  input  logic [15:0]                m_i,
  output logic                       valid_o,
  output awg_pkg::beat_t             beat_o,
  output logic                       flag_o,
  output logic [awg_pkg::DIVD_W-1:0] divd_o
);

  logic                       vld_a_q, vld_b_q;
  awg_pkg::beat_t             pay_a_q, pay_b_q;
  logic [23:0]                num_q;
  logic [15:0]                m_q;
  logic                       flag_a_q, flag_b_q, flag_d;
  logic [awg_pkg::DIVD_W-1:0] divd_q, divd_d;

  // square wants m < H, triangle wants m > H
  always_comb begin
    if (cfg_i.wave == awg_pkg::WAVE_SQUARE) flag_d = m_i < {1'b0, cfg_i.half};
    else                                    flag_d = m_i > {1'b0, cfg_i.half};
  end

  always_comb begin
    if (cfg_i.wave == awg_pkg::WAVE_SINE) begin
      divd_d = awg_pkg::DIVD_W'(m_q) << awg_pkg::ANGLE_W;
    end else if (cfg_i.wave == awg_pkg::WAVE_TRI && flag_a_q) begin
      // ceiling division by H
      divd_d = awg_pkg::DIVD_W'(num_q) + awg_pkg::DIVD_W'(cfg_i.half) - 1'b1;
    end else begin
      divd_d = awg_pkg::DIVD_W'(num_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_a_q  <= beat_i;
    num_q    <= {cfg_i.amp, 1'b0} * m_i;
    m_q      <= m_i;
    flag_a_q <= flag_d;
    pay_b_q  <= pay_a_q;
    flag_b_q <= flag_a_q;
    divd_q   <= divd_d;
  end

  assign valid_o = vld_b_q;
  assign beat_o  = pay_b_q;
  assign flag_o  = flag_b_q;
  assign divd_o  = divd_q;

endmodule

FILE: design/awg_quo.sv
// Pipelined restoring divider giving QUO_W quotient bits, STEPS bits a stage.
// Depends on awg_pkg.
module awg_quo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  awg_pkg::cfg_t              cfg_i,
  input  logic                       valid_i,
  input  awg_pkg::beat_t             beat_i,
  input  logic                       flag_i,
  input  logic [awg_pkg::DIVD_W-1:0] divd_i,
  output logic                       valid_o,
  output awg_pkg::beat_t             beat_o,
  output logic                       flag_o,
  output logic [awg_pkg::QUO_W-1:0]  quo_o
);

  logic                       vld_q  [0:awg_pkg::QUO_STAGES];
  awg_pkg::beat_t             pay_q  [0:awg_pkg::QUO_STAGES];
  logic                       flg_q  [0:awg_pkg::QUO_STAGES];
  logic [awg_pkg::DIVD_W-1:0] rem_q  [0:awg_pkg::QUO_STAGES];
  logic [awg_pkg::QUO_W-1:0]  quo_q  [0:awg_pkg::QUO_STAGES];
  logic [15:0]                divisor;

  assign divisor = (cfg_i.wave == awg_pkg::WAVE_TRI) ? {1'b0, cfg_i.half} : cfg_i.period;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else         vld_q[0] <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    pay_q[0] <= beat_i;
    flg_q[0] <= flag_i;
    rem_q[0] <= divd_i;
    quo_q[0] <= '0;
  end

  for (genvar g = 0; g < awg_pkg::QUO_STAGES; g++) begin : g_stage
    logic [awg_pkg::DIVD_W-1:0] rem_d;
    logic [awg_pkg::QUO_W-1:0]  quo_d;
    always_comb begin
      rem_d = rem_q[g];
      quo_d = quo_q[g];
      for (int k = 0; k < awg_pkg::STEPS; k++) begin
        if (int'(awg_pkg::QUO_W) - 1 - g * int'(awg_pkg::STEPS) - k >= 0) begin
          if ({1'b0, rem_d} >= ((awg_pkg::DIVD_W + 1)'(divisor)
              << (awg_pkg::QUO_W - 1 - g * awg_pkg::STEPS - k))) begin
            rem_d = rem_d - awg_pkg::DIVD_W'((awg_pkg::DIVD_W + 1)'(divisor)
                    << (awg_pkg::QUO_W - 1 - g * awg_pkg::STEPS - k));
            quo_d[awg_pkg::QUO_W - 1 - g * awg_pkg::STEPS - k] = 1'b1;
          end
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[g+1] <= 1'b0;
      else         vld_q[g+1] <= vld_q[g];
    end
    always_ff @(posedge clk_i) begin
      pay_q[g+1] <= pay_q[g];
      flg_q[g+1] <= flg_q[g];
      rem_q[g+1] <= rem_d;
      quo_q[g+1] <= quo_d;
    end
  end

  assign valid_o = vld_q[awg_pkg::QUO_STAGES];
  assign beat_o  = pay_q[awg_pkg::QUO_STAGES];
  assign flag_o  = flg_q[awg_pkg::QUO_STAGES];
  assign quo_o   = quo_q[awg_pkg::QUO_STAGES];

endmodule

FILE: design/awg_post.sv
// Sine lookup and scaling, linear shapes, centre offset and clamp to 0..127.
// Depends on awg_pkg.
module awg_post (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  awg_pkg::cfg_t             cfg_i,
  input  logic                      valid_i,
  input  awg_pkg::beat_t            beat_i,
  input  logic                      flag_i,
  input  logic [awg_pkg::QUO_W-1:0] quo_i,
  output logic                      valid_o,
  output awg_pkg::beat_t            beat_o,
  output logic [6:0]                level_o
);

  logic [awg_pkg::ANGLE_W-1:0] angle;
  logic [1:0]                  quad;
  logic [awg_pkg::IDX_W:0]     idx;
  logic signed [10:0]          cen, amp, qv, lin_d, sine_pt, pt;
  logic [6:0]                  mag;

  logic                        vld1_q, vld2_q, vld3_q;
  awg_pkg::beat_t              pay1_q, pay2_q, pay3_q;
  logic [14:0]                 sv_q;
  logic                        neg1_q, neg2_q;
  logic signed [10:0]          lin1_q, lin2_q;
  logic [21:0]                 prod_q;
  logic [6:0]                  level_q;

  assign angle = quo_i[awg_pkg::ANGLE_W-1:0];
  assign quad  = angle[awg_pkg::ANGLE_W-1 -: 2];
  assign idx   = quad[0] ? (awg_pkg::IDX_W + 1)'(awg_pkg::QUARTER_SINE_ENTRIES)
                           - {1'b0, angle[awg_pkg::IDX_W-1:0]}
                         : {1'b0, angle[awg_pkg::IDX_W-1:0]};

  assign cen = 11'(cfg_i.center);
  assign amp = 11'(cfg_i.amp);
  assign qv  = 11'(quo_i[8:0]);   // linear shapes never exceed 9 quotient bits

  always_comb begin
    unique case (cfg_i.wave)
      awg_pkg::WAVE_SQUARE: lin_d = flag_i ? cen + amp : cen - amp;
      awg_pkg::WAVE_SAW:    lin_d = cen - amp + qv;
      awg_pkg::WAVE_TRI:    lin_d = flag_i ? cen + 11'sd3 * amp - qv : cen - amp + qv;
      default:              lin_d = cen;
    endcase
  end

  assign mag     = prod_q[21:15];
  assign sine_pt = neg2_q ? cen - 11'(mag) : cen + 11'(mag);
  assign pt      = (cfg_i.wave == awg_pkg::WAVE_SINE) ? sine_pt : lin2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pay1_q <= beat_i;
    sv_q   <= awg_pkg::SINE_TABLE[idx];
    neg1_q <= quad[1];
    lin1_q <= lin_d;
    pay2_q <= pay1_q;
    prod_q <= cfg_i.amp * sv_q;
    neg2_q <= neg1_q;
    lin2_q <= lin1_q;
    pay3_q <= pay2_q;
    if (pt < 0)              level_q <= 7'd0;
    else if (pt > 11'sd127)  level_q <= 7'd127;
    else                     level_q <= pt[6:0];
  end

  assign valid_o = vld3_q;
  assign beat_o  = pay3_q;
  assign level_o = level_q;

endmodule

FILE: design/automation_waveform_generator.sv
// Automation waveform generator top level: configuration registers and pipeline.
// Depends on awg_pkg, awg_mod, awg_prep, awg_quo, awg_post.
//
// Usage notes
// - Input: a point is taken at each rising edge where start is high and busy is
//   low. busy never rises, so one point can enter every clock.
// - Output: each result beat shows on level_o, position_out_o and last_out_o for
//   exactly one cycle, flagged by result_valid_o; the receiver cannot stall.
// - Stages: input register, modulo, prep, quotient input register, quotient,
//   post. Throughput one point per clock, results in order.
// - The depth comes from two restoring dividers (the period modulo and the
//   shared quotient for sine angle, sawtooth and triangle), four bits a stage,
//   then table lookup, amplitude multiply and clamp.
// - Config: write cfg_we_i/cfg_idx_i/cfg_wdata_i only with no point in flight;
//   registers are read live by every stage. Unused indices are dropped.
// - Reset clears the in-flight valid bits and loads the default registers
//   (flat, amplitude 0, period 24, phase 0, centre 63).
module automation_waveform_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] position_i,
  input  logic        last_in_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        result_valid_o,
  output logic [6:0]  level_o,
  output logic [15:0] position_out_o,
  output logic        last_out_o
);

  logic [2:0]  wave_q;
  logic [6:0]  amp_q, center_q;
  logic [15:0] period_q, phase_q;
  logic [15:0] period_eff;
  awg_pkg::cfg_t cfg;

  logic                       mod_vld, prep_vld, quo_vld, post_vld, flag_p, flag_q;
  awg_pkg::beat_t             in_beat, mod_beat, prep_beat, quo_beat, post_beat;
  logic [15:0]                m;
  logic [awg_pkg::DIVD_W-1:0] divd;
  logic [awg_pkg::QUO_W-1:0]  quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q   <= awg_pkg::WAVE_FLAT;
      amp_q    <= 7'd0;
      period_q <= 16'd24;
      phase_q  <= 16'd0;
      center_q <= 7'd63;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        awg_pkg::CFG_WAVEFORM:  wave_q   <= cfg_wdata_i[2:0];
        awg_pkg::CFG_AMPLITUDE: amp_q    <= cfg_wdata_i[6:0];
        awg_pkg::CFG_PERIOD:    period_q <= cfg_wdata_i;
        awg_pkg::CFG_PHASE:     phase_q  <= cfg_wdata_i;
        awg_pkg::CFG_CENTER:    center_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // period of 0 or 1 runs as 2
  assign period_eff = (period_q < 16'd2) ? 16'd2 : period_q;

  assign cfg.wave   = wave_q;
  assign cfg.amp    = amp_q;
  assign cfg.period = period_eff;
  assign cfg.half   = period_eff[15:1];
  assign cfg.phase  = phase_q;
  assign cfg.center = center_q;

  assign busy             = 1'b0;
  assign in_beat.position = position_i;
  assign in_beat.last     = last_in_i;

  awg_mod u_mod (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .valid_i(start & ~busy), .beat_i(in_beat),
    .valid_o(mod_vld), .beat_o(mod_beat), .m_o(m)
  );

  awg_prep u_prep (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .valid_i(mod_vld), .beat_i(mod_beat), .m_i(m),
    .valid_o(prep_vld), .beat_o(prep_beat), .flag_o(flag_p), .divd_o(divd)
  );

  awg_quo u_quo (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .valid_i(prep_vld), .beat_i(prep_beat), .flag_i(flag_p), .divd_i(divd),
    .valid_o(quo_vld), .beat_o(quo_beat), .flag_o(flag_q), .quo_o(quo)
  );

  awg_post u_post (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .valid_i(quo_vld), .beat_i(quo_beat), .flag_i(flag_q), .quo_i(quo),
    .valid_o(post_vld), .beat_o(post_beat), .level_o(level_o)
  );

  assign result_valid_o = post_vld;
  assign position_out_o = post_beat.position;
  assign last_out_o     = post_beat.last;

endmodule

FILE: design/awg_chk.sv
// Port-level checker for the automation waveform generator, bound to the top.
// Depends on awg_pkg and automation_waveform_generator_defines.svh.
`include "automation_waveform_generator_defines.svh"

module awg_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [15:0] position_i,
  input logic        last_in_i,
  input logic        result_valid_o,
  input logic [15:0] position_out_o,
  input logic        last_out_o
);

  `AWG_ASSERT_IMP(a_beat_out, start && !busy, ##(awg_pkg::LATENCY) result_valid_o, "beat lost")
  `AWG_ASSERT_IMP(a_no_extra, result_valid_o, $past(start && !busy, awg_pkg::LATENCY), "beat invented")
  `AWG_ASSERT_IMP(a_payload, result_valid_o, position_out_o == $past(position_i, awg_pkg::LATENCY) && last_out_o == $past(last_in_i, awg_pkg::LATENCY), "payload mismatch")

endmodule

bind automation_waveform_generator awg_chk u_awg_chk (.*);

FILE: tb/sv/tb_automation_waveform_generator.sv
// Self-checking testbench for the automation waveform generator: directed and random points
// across many register settings, each result checked against a built-in level predictor.
// Depends on awg_pkg and automation_waveform_generator.
`timescale 1ns / 100ps

module tb_automation_waveform_generator;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = awg_pkg::LATENCY + 8;
  localparam logic [2:0] CFG_SPARE = 3'd5;  // index the block ignores
  localparam logic [2:0] WAVE_SPARE = 3'd7; // unused code, behaves as flat

  typedef struct {
    logic [15:0] pos;
    logic        last;
  } point_t;

  typedef struct {
    logic [6:0]  level;
    logic [15:0] pos;
    logic        last;
  } level_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] position_i = '0;
  logic        last_in_i = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        result_valid_o;
  logic [6:0]  level_o;
  logic [15:0] position_out_o;
  logic        last_out_o;

  // Shadow of the block's registers, reset values as after rst_ni.
  logic [2:0]  sh_wave = awg_pkg::WAVE_FLAT;
  logic [6:0]  sh_amp = 7'd0;
  logic [15:0] sh_period = 16'd24;
  logic [15:0] sh_phase = 16'd0;
  logic [6:0]  sh_center = 7'd63;

  int          quarter_tab [0:awg_pkg::QUARTER_SINE_ENTRIES];
  point_t      pending_q[$];
  level_beat_t level_q[$];
  int unsigned idle_pct = 11;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;

  automation_waveform_generator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .position_i     (position_i),
    .last_in_i      (last_in_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .level_o        (level_o),
    .position_out_o (position_out_o),
    .last_out_o     (last_out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Quarter sine in Q0.15: Q30 Taylor series up to x^15, each term truncated.
  function automatic int quarter_sine_q15(int unsigned i);
    logic [63:0] x, x2, term, pos_sum, neg_sum, s;
    if (i >= awg_pkg::QUARTER_SINE_ENTRIES) return 32767;
    x = (64'd1686629713 * 64'(i)) / 64'(awg_pkg::QUARTER_SINE_ENTRIES);
    x2 = (x * x) >> 30;
    term = x;
    pos_sum = x;
    neg_sum = '0;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) neg_sum += term;
      else pos_sum += term;
    end
    s = (neg_sum > pos_sum) ? 64'd0 : pos_sum - neg_sum;
    if (s > 64'd1073741824) s = 64'd1073741824;
    return int'((s * 64'd32767 + 64'd536870912) >> 30);
  endfunction

  // Level for one point under the current shadow registers.
  function automatic logic [6:0] predict_level(logic [15:0] pos);
    int p, m, h, a, c, num, pt, ang, quad, r, v, mag;
    p = (sh_period < 16'd2) ? 2 : int'(sh_period);
    m = (int'(pos) + int'(sh_phase)) % p;
    h = p / 2;
    a = int'(sh_amp);
    c = int'(sh_center);
    num = 2 * a * m;
    case (sh_wave)
      awg_pkg::WAVE_SINE: begin
        ang = (m * 4 * awg_pkg::QUARTER_SINE_ENTRIES) / p;
        quad = ang / awg_pkg::QUARTER_SINE_ENTRIES;
        r = ang % awg_pkg::QUARTER_SINE_ENTRIES;
        v = (quad == 0 || quad == 2) ? quarter_tab[r]
                                     : quarter_tab[awg_pkg::QUARTER_SINE_ENTRIES - r];
        mag = (a * v) >>> 15;
        pt = (quad >= 2) ? c - mag : c + mag;
      end
      awg_pkg::WAVE_SQUARE: pt = (m < h) ? c + a : c - a;
      awg_pkg::WAVE_SAW:    pt = c - a + num / p;
      awg_pkg::WAVE_TRI:    pt = (m > h) ? c + 3 * a - (num + h - 1) / h : c - a + num / h;
      default:              pt = c;
    endcase
    if (pt > 127) pt = 127;
    if (pt < 0) pt = 0;
    return 7'(pt);
  endfunction

  // Driver: presents the head of pending_q; a beat goes when start is high and busy low.
  always @(posedge clk_i or negedge rst_ni) begin
    point_t      pt_now;
    level_beat_t lb;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pt_now = pending_q.pop_front();
        lb.level = predict_level(pt_now.pos);
        lb.pos = pt_now.pos;
        lb.last = pt_now.last;
        level_q = {level_q, lb};
      end
      if (start && busy) begin
        // held beat stays as it is
      end else if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        position_i <= pending_q[0].pos;
        last_in_i <= pending_q[0].last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result must match the oldest expected level beat.
  always @(posedge clk_i) begin
    level_beat_t lb;
    if (rst_ni && result_valid_o) begin
      if (level_q.size() == 0) begin
        $display("%0t: unexpected result level=%0d pos=%0d last=%0b", $time, level_o,
                 position_out_o, last_out_o);
        fail_cnt++;
      end else begin
        lb = level_q.pop_front();
        if (level_o !== lb.level || position_out_o !== lb.pos || last_out_o !== lb.last) begin
          $display("%0t: mismatch pos=%0d exp level=%0d pos=%0d last=%0b got level=%0d pos=%0d last=%0b",
                   $time, lb.pos, lb.level, lb.pos, lb.last, level_o, position_out_o, last_out_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL automation_waveform_generator");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      awg_pkg::CFG_WAVEFORM:  sh_wave = data[2:0];
      awg_pkg::CFG_AMPLITUDE: sh_amp = data[6:0];
      awg_pkg::CFG_PERIOD:    sh_period = data;
      awg_pkg::CFG_PHASE:     sh_phase = data;
      awg_pkg::CFG_CENTER:    sh_center = data[6:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits out every beat in flight, then loads all five registers; the
  // narrow ones get random junk above their width.
  task automatic load_setting(logic [2:0] w, logic [6:0] a, logic [15:0] p, logic [15:0] ph,
                              logic [6:0] c);
    while (pending_q.size() > 0 || level_q.size() > 0 || start) @(posedge clk_i);
    write_reg(awg_pkg::CFG_WAVEFORM, {16'($urandom) & 16'hFFF8} | 16'(w));
    write_reg(awg_pkg::CFG_AMPLITUDE, {16'($urandom) & 16'hFF80} | 16'(a));
    write_reg(awg_pkg::CFG_PERIOD, p);
    write_reg(awg_pkg::CFG_PHASE, ph);
    write_reg(awg_pkg::CFG_CENTER, {16'($urandom) & 16'hFF80} | 16'(c));
  endtask

  task automatic queue_point(logic [15:0] pos, logic last);
    point_t pt_new;
    pt_new.pos = pos;
    pt_new.last = last;
    pending_q = {pending_q, pt_new};
  endtask

  initial begin
    logic [2:0]  w;
    logic [6:0]  a, c;
    logic [15:0] p, base;
    int unsigned run;
    for (int i = 0; i <= awg_pkg::QUARTER_SINE_ENTRIES; i++) quarter_tab[i] = quarter_sine_q15(i);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset values give the flat centre.
    queue_point(16'd0, 1'b0);
    queue_point(16'hFFFF, 1'b1);
    // Sine on quadrant boundaries, full amplitude.
    load_setting(awg_pkg::WAVE_SINE, 7'd127, 16'd16, 16'd0, 7'd63);
    queue_point(16'd0, 1'b0);
    queue_point(16'd4, 1'b1);
    queue_point(16'd8, 1'b0);
    queue_point(16'd12, 1'b1);
    queue_point(16'hFFFF, 1'b0);
    // Short period of one, square clamped high.
    load_setting(awg_pkg::WAVE_SQUARE, 7'd127, 16'd1, 16'd0, 7'd127);
    queue_point(16'd0, 1'b1);
    queue_point(16'd1, 1'b0);
    // Period of zero, sawtooth clamped low.
    load_setting(awg_pkg::WAVE_SAW, 7'd127, 16'd0, 16'd0, 7'd0);
    queue_point(16'd0, 1'b0);
    queue_point(16'd1, 1'b1);
    // Triangle with odd period and phase wrapping past 16 bits.
    load_setting(awg_pkg::WAVE_TRI, 7'd100, 16'd7, 16'hFFFF, 7'd63);
    queue_point(16'd1, 1'b0);
    queue_point(16'd3, 1'b1);
    queue_point(16'd4, 1'b0);
    queue_point(16'd6, 1'b1);
    load_setting(awg_pkg::WAVE_TRI, 7'd127, 16'd2, 16'd0, 7'd63);
    queue_point(16'd0, 1'b1);
    queue_point(16'd1, 1'b0);
    // Unused waveform code acts as flat; also poke the ignored index.
    load_setting(WAVE_SPARE, 7'd127, 16'hFFFF, 16'hFFFF, 7'd5);
    write_reg(CFG_SPARE, 16'hFFFF);
    queue_point(16'd0, 1'b0);
    queue_point(16'hFFFF, 1'b1);
    // Longest period sine, negative half clamps at zero.
    load_setting(awg_pkg::WAVE_SINE, 7'd127, 16'hFFFF, 16'd0, 7'd0);
    queue_point(16'd1, 1'b0);
    queue_point(16'd16384, 1'b0);
    queue_point(16'd49151, 1'b1);

    // Random settings: mostly lanes of consecutive points, some scattered.
    for (int ph = 0; ph < 30; ph++) begin
      w = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
      a = ($urandom_range(5) == 0) ? (($urandom_range(1) == 0) ? 7'd0 : 7'd127) : 7'($urandom);
      c = ($urandom_range(5) == 0) ? (($urandom_range(1) == 0) ? 7'd0 : 7'd127) : 7'($urandom);
      case ($urandom_range(9))
        0:       p = 16'($urandom_range(0, 3));
        1:       p = 16'($urandom);
        default: p = 16'($urandom_range(2, 400));
      endcase
      load_setting(w, a, p, 16'($urandom), c);
      idle_pct = (ph < 10) ? 11 : (ph < 20) ? 69 : 0;
      for (int n = 0; n < 26; n += run) begin
        run = $urandom_range(1, 12);
        base = 16'($urandom);
        if ($urandom_range(3) == 0) begin
          for (int k = 0; k < run; k++) queue_point(16'($urandom), 1'($urandom));
        end else begin
          for (int k = 0; k < run; k++) queue_point(base + 16'(k), k == run - 1);
        end
      end
    end

    while (pending_q.size() > 0 || level_q.size() > 0 || start) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("PASS automation_waveform_generator");
    end else begin
      $display("FAIL automation_waveform_generator");
    end
    $finish;
  end

endmodule
